[src/sorted_priority_queue_macros.svh]
// assertion macros for the sorted priority queue
// used by the top level; needs nothing else
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

[src/spq_pkg.sv]
// shared constants for the sorted priority queue
// no dependencies
package spq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT   = 16;
   localparam int PRIORITY_BITS_DEFAULT = 8;
   localparam int VALUE_BITS_DEFAULT    = 32;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

[src/spq_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/sorted_priority_queue.sv]
// sorted priority queue: circular buffer in one ram, insertion by backward scan
// path: dequeue IDLE-DEQ-FIN, enqueue IDLE-CMP scan-(PUT)-FIN, refused or into empty IDLE-FIN
// throughput: one item at a time; enqueue cost grows with the entries it passes,
// one ram read and one write per cycle of the scan
// reset: synchronous, empties the queue at once, no clearing pass
// depends on spq_pkg, spq_ram and sorted_priority_queue_macros.svh
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
   parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [PRIORITY_BITS-1:0]         req_item_priority,
   input  logic [VALUE_BITS-1:0]            req_item_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [VALUE_BITS-1:0]            rsp_out_value,
   output logic [PRIORITY_BITS-1:0]         rsp_out_priority,
   output logic [1:0]                       rsp_status,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_entry_count
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int WW = PRIORITY_BITS + VALUE_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DEQ  = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_PUT  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [IW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            ptr_ff, ptr_in;
   logic [IW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]            left_ff, left_in;
   logic [WW-1:0]            item_ff, item_in;
   logic [VALUE_BITS-1:0]    pend_value_ff, pend_value_in;
   logic [PRIORITY_BITS-1:0] pend_prio_ff, pend_prio_in;
   logic [1:0]               pend_status_ff, pend_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [CW-1:0]            rsp_count_ff, rsp_count_in;

   logic                     ram_wr_en, ram_rd_en;
   logic [IW-1:0]            ram_wr_addr, ram_rd_addr;
   logic [WW-1:0]            ram_wr_data, ram_rd_data;

   logic [SW-1:0]            tail_sum;
   logic [IW-1:0]            tail, last;
   logic [IW-1:0]            ptr_dec;
   logic                     req_fire, slot_free;

   spq_ram #(
      .WIDTH(WW),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (tail_sum >= SW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SW'(QUEUE_DEPTH);
      end
      tail    = tail_sum[IW-1:0];
      last    = (tail == '0) ? IW'(QUEUE_DEPTH - 1) : tail - 1'b1;
      ptr_dec = (ptr_ff == '0) ? IW'(QUEUE_DEPTH - 1) : ptr_ff - 1'b1;
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      left_in        = left_ff;
      item_in        = item_ff;
      pend_value_in  = pend_value_ff;
      pend_prio_in   = pend_prio_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = wr_ptr_ff;
      ram_wr_data    = item_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = ptr_dec;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in        = {req_item_priority, req_item_value};
               pend_value_in  = '0;
               pend_prio_in   = '0;
               pend_status_in = spq_pkg::STATUS_DONE;
               state_in       = ST_FIN;
               if (req_mode == spq_pkg::MODE_DEQUEUE) begin
                  if (count_ff == '0) begin
                     pend_status_in = spq_pkg::STATUS_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                     head_in     = (head_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     count_in    = count_ff - 1'b1;
                     state_in    = ST_DEQ;
                  end
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  pend_status_in = spq_pkg::STATUS_FULL;
               end else if (count_ff == '0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = tail;
                  ram_wr_data = {req_item_priority, req_item_value};
                  count_in    = count_ff + 1'b1;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = last;
                  ptr_in      = last;
                  wr_ptr_in   = tail;
                  left_in     = count_ff;
                  count_in    = count_ff + 1'b1;
                  state_in    = ST_CMP;
               end
            end
         end
         ST_DEQ: begin
            pend_prio_in  = ram_rd_data[VALUE_BITS +: PRIORITY_BITS];
            pend_value_in = ram_rd_data[VALUE_BITS-1:0];
            state_in      = ST_FIN;
         end
         ST_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data[VALUE_BITS +: PRIORITY_BITS] <
                item_ff[VALUE_BITS +: PRIORITY_BITS]) begin
               ram_wr_data = ram_rd_data;
               wr_ptr_in   = ptr_ff;
               if (left_ff == CW'(1)) begin
                  state_in = ST_PUT;
               end else begin
                  ram_rd_en = 1'b1;
                  ptr_in    = ptr_dec;
                  left_in   = left_ff - 1'b1;
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_PUT: begin
            ram_wr_en = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_prio_in   = pend_prio_ff;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      left_ff        <= left_in;
      item_ff        <= item_in;
      pend_value_ff  <= pend_value_in;
      pend_prio_ff   <= pend_prio_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   `SPQ_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_fire, !req_ready)
   `SPQ_ASSERT_IMPL(a_count_bounded, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   `SPQ_ASSERT_IMPL(a_scan_has_entries, clock, reset, state_ff == ST_CMP, left_ff != '0)
   `SPQ_ASSERT_IMPL(a_full_count, clock, reset,
      rsp_valid_ff && rsp_status_ff == spq_pkg::STATUS_FULL,
      rsp_count_ff == CW'(QUEUE_DEPTH))
   `SPQ_ASSERT_IMPL(a_empty_count, clock, reset,
      rsp_valid_ff && rsp_status_ff == spq_pkg::STATUS_EMPTY, rsp_count_ff == '0)

endmodule
